@@ rtl/core/linear_array_queue_top_defines.svh @@
// assertion macros for the linear array queue
`ifndef LINEAR_ARRAY_QUEUE_TOP_DEFINES_SVH
`define LINEAR_ARRAY_QUEUE_TOP_DEFINES_SVH

`ifndef ASSERT_OFF
`define LAQ_ASSERT_ALWAYS(lbl, clk, rstn, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (expr)) \
    else $error("laq assertion failed");
`define LAQ_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
    else $error("laq assertion failed");
`else
`define LAQ_ASSERT_ALWAYS(lbl, clk, rstn, expr)
`define LAQ_ASSERT_IMPLIES(lbl, clk, rstn, ante, cons)
`endif

`endif

@@ rtl/core/laq_pkg.sv @@
// shared types and constants of the linear array queue
`timescale 1ns / 1ps

package laq_pkg;

  // default slot count
  localparam int DEPTH_DEF = 256;

  // capacity register
  localparam int CAP_W = 9;
  localparam logic [CAP_W-1:0] CAP_RESET = 9'd256;

  // word and result count widths
  localparam int WORD_W = 32;
  localparam int OUT_CNT_W = 9;

  // configuration address map
  localparam int CFG_AW = 3;
  localparam int CFG_DW = 32;
  localparam logic CFG_IDX_CAP = 1'b0;

  typedef enum logic [1:0] {
    REQ_ENQ        = 2'd0,
    REQ_DEQ        = 2'd1,
    REQ_PEEK_FRONT = 2'd2,
    REQ_PEEK_REAR  = 2'd3
  } laq_req_t;

  typedef enum logic [1:0] {
    ST_DONE  = 2'd0,
    ST_FULL  = 2'd1,
    ST_EMPTY = 2'd2
  } laq_status_t;

  typedef struct packed {
    laq_req_t                  req_type;
    logic signed [WORD_W-1:0]  push_value;
  } laq_in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0]  read_value;
    laq_status_t               status;
    logic                      full_flag;
    logic                      empty_flag;
    logic [OUT_CNT_W-1:0]      item_count;
  } laq_out_t;

endpackage

@@ rtl/core/laq_ram.sv @@
// generic single-port-write, single-port-read ram with registered read
`timescale 1ns / 1ps

module laq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 256,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ rtl/core/laq_cfg.sv @@
// apb-style register file holding the queue capacity
`timescale 1ns / 1ps

module laq_cfg (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [laq_pkg::CFG_AW-1:0]  paddr,
  input  logic [laq_pkg::CFG_DW-1:0]  pwdata,
  output logic [laq_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready,
  output logic [laq_pkg::CAP_W-1:0]   cap
);

  logic [laq_pkg::CAP_W-1:0] cap_r;
  logic [laq_pkg::CAP_W-1:0] cap_nxt;
  logic                      wr_hit;

  assign pready = 1'b1;

  // register index is the word address
  assign wr_hit = psel && penable && pwrite
                  && (paddr[laq_pkg::CFG_AW-1] == laq_pkg::CFG_IDX_CAP);

  always_comb begin
    cap_nxt = cap_r;
    if (wr_hit) begin
      cap_nxt = pwdata[laq_pkg::CAP_W-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cap_r <= laq_pkg::CAP_RESET;
    end else begin
      cap_r <= cap_nxt;
    end
  end

  // read back
  always_comb begin
    prdata = '0;
    if (paddr[laq_pkg::CFG_AW-1] == laq_pkg::CFG_IDX_CAP) begin
      prdata = laq_pkg::CFG_DW'(cap_r);
    end
  end

  assign cap = cap_r;

endmodule

@@ rtl/core/laq_ctrl.sv @@
// queue pointers, request decode and result formation around the slot ram
`timescale 1ns / 1ps
`include "linear_array_queue_top_defines.svh"

module laq_ctrl #(
  parameter int DEPTH = laq_pkg::DEPTH_DEF,
  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             accept,
  input  laq_pkg::laq_in_t                 in_data,
  input  logic [laq_pkg::CAP_W-1:0]        cap,
  output logic                             ram_we,
  output logic [PTR_W-1:0]                 ram_waddr,
  output logic [laq_pkg::WORD_W-1:0]       ram_wdata,
  output logic                             ram_re,
  output logic [PTR_W-1:0]                 ram_raddr,
  input  logic [laq_pkg::WORD_W-1:0]       ram_rdata,
  output logic                             out_valid,
  output laq_pkg::laq_out_t                out_data
);

  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int CMP_W = (PTR_W + 1 > laq_pkg::CAP_W) ? PTR_W + 1 : laq_pkg::CAP_W;
  localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

  logic [PTR_W-1:0] head_r, head_nxt;
  logic [PTR_W-1:0] tail_r, tail_nxt;
  logic             empty_r, empty_nxt;
  logic [CNT_W-1:0] cnt_r, cnt_nxt;

  logic                  out_valid_r;
  laq_pkg::laq_status_t  res_status_r, res_status_nxt;
  logic                  res_full_r, res_full_nxt;
  logic                  rsel_r, rsel_nxt;

  logic [CMP_W-1:0] cap_ext;
  logic [CMP_W-1:0] eff_cap;
  logic [CMP_W-1:0] lim;
  logic             full_now;
  logic [PTR_W-1:0] tail_inc;

  // effective capacity clamped to one .. depth
  assign cap_ext = CMP_W'(cap);
  always_comb begin
    if (cap == '0) begin
      eff_cap = CMP_W'(1);
    end else if (cap_ext > DEPTH_C) begin
      eff_cap = DEPTH_C;
    end else begin
      eff_cap = cap_ext;
    end
  end
  assign lim      = eff_cap - CMP_W'(1);
  assign full_now = !empty_r && (CMP_W'(tail_r) >= lim);
  assign tail_inc = tail_r + PTR_W'(1);

  // request decode, pointer update and ram access
  always_comb begin
    head_nxt       = head_r;
    tail_nxt       = tail_r;
    empty_nxt      = empty_r;
    cnt_nxt        = cnt_r;
    res_status_nxt = laq_pkg::ST_DONE;
    rsel_nxt       = 1'b0;
    ram_we         = 1'b0;
    ram_waddr      = tail_inc;
    ram_raddr      = head_r;
    if (accept) begin
      if (in_data.req_type == laq_pkg::REQ_ENQ) begin
        if (full_now) begin
          res_status_nxt = laq_pkg::ST_FULL;
        end else if (empty_r) begin
          ram_we    = 1'b1;
          ram_waddr = '0;
          head_nxt  = '0;
          tail_nxt  = '0;
          empty_nxt = 1'b0;
          cnt_nxt   = CNT_W'(1);
        end else begin
          ram_we   = 1'b1;
          tail_nxt = tail_inc;
          cnt_nxt  = cnt_r + CNT_W'(1);
        end
      end else if (empty_r) begin
        res_status_nxt = laq_pkg::ST_EMPTY;
      end else begin
        unique case (in_data.req_type)
          laq_pkg::REQ_DEQ: begin
            rsel_nxt = 1'b1;
            if (head_r >= tail_r) begin
              head_nxt  = '0;
              tail_nxt  = '0;
              empty_nxt = 1'b1;
              cnt_nxt   = '0;
            end else begin
              head_nxt = head_r + PTR_W'(1);
              cnt_nxt  = cnt_r - CNT_W'(1);
            end
          end
          laq_pkg::REQ_PEEK_FRONT: begin
            rsel_nxt = 1'b1;
          end
          laq_pkg::REQ_PEEK_REAR: begin
            rsel_nxt  = 1'b1;
            ram_raddr = tail_r;
          end
          default: begin
            rsel_nxt = 1'b0;
          end
        endcase
      end
    end
    res_full_nxt = !empty_nxt && (CMP_W'(tail_nxt) >= lim);
  end

  assign ram_wdata = in_data.push_value;
  assign ram_re    = accept;

  // queue state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r      <= '0;
      tail_r      <= '0;
      empty_r     <= 1'b1;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      head_r      <= head_nxt;
      tail_r      <= tail_nxt;
      empty_r     <= empty_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= accept;
    end
  end

  // result fields
  always_ff @(posedge clk) begin
    res_status_r <= res_status_nxt;
    res_full_r   <= res_full_nxt;
    rsel_r       <= rsel_nxt;
  end

  // state registers already hold the after-step values during the strobe
  assign out_valid           = out_valid_r;
  assign out_data.read_value = rsel_r ? ram_rdata : '0;
  assign out_data.status     = res_status_r;
  assign out_data.full_flag  = res_full_r;
  assign out_data.empty_flag = empty_r;
  assign out_data.item_count = laq_pkg::OUT_CNT_W'(cnt_r);

  `LAQ_ASSERT_IMPLIES(a_empty_clean, clk, rst_n, empty_r,
    (cnt_r == '0) && (head_r == '0) && (tail_r == '0))
  `LAQ_ASSERT_IMPLIES(a_ptr_order, clk, rst_n, !empty_r, head_r <= tail_r)
  `LAQ_ASSERT_IMPLIES(a_count_span, clk, rst_n, !empty_r,
    cnt_r == (CNT_W'(tail_r) - CNT_W'(head_r) + CNT_W'(1)))
  `LAQ_ASSERT_IMPLIES(a_strobe_follows, clk, rst_n, out_valid_r, $past(accept))

endmodule

@@ rtl/core/linear_array_queue_top.sv @@
// linear array queue: each request gives one result in the cycle after start
// one request per cycle, busy stays low; the slot ram read sets the latency
// full, empty and count reflect the queue after the request
// synchronous active-low reset empties the queue and sets capacity to 256
// slot contents are not cleared; only written slots are ever returned in a result
`timescale 1ns / 1ps

module linear_array_queue_top #(
  parameter int DEPTH = laq_pkg::DEPTH_DEF
) (
  input  logic                        clk,
  input  logic                        rst_n,
  input  logic                        start,
  output logic                        busy,
  input  laq_pkg::laq_in_t            in_data,
  output logic                        out_valid,
  output laq_pkg::laq_out_t           out_data,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [laq_pkg::CFG_AW-1:0]  paddr,
  input  logic [laq_pkg::CFG_DW-1:0]  pwdata,
  output logic [laq_pkg::CFG_DW-1:0]  prdata,
  output logic                        pready
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;

  logic [laq_pkg::CAP_W-1:0]  cap;
  logic                       accept;
  logic                       ram_we;
  logic [PTR_W-1:0]           ram_waddr;
  logic [laq_pkg::WORD_W-1:0] ram_wdata;
  logic                       ram_re;
  logic [PTR_W-1:0]           ram_raddr;
  logic [laq_pkg::WORD_W-1:0] ram_rdata;

  // no request ever stalls on its ram access, so busy is tied low
  assign busy   = 1'b0;
  assign accept = start && !busy;

  laq_cfg u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cap     (cap)
  );

  laq_ram #(
    .WIDTH (laq_pkg::WORD_W),
    .DEPTH (DEPTH)
  ) u_slots (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  laq_ctrl #(
    .DEPTH (DEPTH)
  ) u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .in_data   (in_data),
    .cap       (cap),
    .ram_we    (ram_we),
    .ram_waddr (ram_waddr),
    .ram_wdata (ram_wdata),
    .ram_re    (ram_re),
    .ram_raddr (ram_raddr),
    .ram_rdata (ram_rdata),
    .out_valid (out_valid),
    .out_data  (out_data)
  );

endmodule

@@ test/linear_array_queue_top_test.sv @@
// testbench of the linear array queue: shadow queue predicts every result, random traffic
`timescale 1ns / 1ps

module linear_array_queue_top_test;

  localparam int SLOTS = laq_pkg::DEPTH_DEF;
  localparam logic [laq_pkg::CFG_AW-1:0] CAP_ADDR = {laq_pkg::CFG_IDX_CAP, 2'b00};
  localparam logic [laq_pkg::WORD_W-1:0] SENTINEL = -32'sd999999;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  logic busy;
  laq_pkg::laq_in_t in_data = '0;
  logic out_valid;
  laq_pkg::laq_out_t out_data;
  logic psel = 1'b0;
  logic penable = 1'b0;
  logic pwrite = 1'b0;
  logic [laq_pkg::CFG_AW-1:0] paddr = '0;
  logic [laq_pkg::CFG_DW-1:0] pwdata = '0;
  logic [laq_pkg::CFG_DW-1:0] prdata;
  logic pready;

  // shadow copy of the queue state
  logic [laq_pkg::WORD_W-1:0] shadow_slots [SLOTS];
  int unsigned shadow_head = 0;
  int unsigned shadow_tail = 0;
  int unsigned shadow_held = 0;
  bit shadow_empty = 1'b1;
  logic [laq_pkg::CAP_W-1:0] shadow_cap = laq_pkg::CAP_RESET;

  laq_pkg::laq_out_t pending_answers [$];
  int mismatch_count = 0;
  int idle_max = 15;

  linear_array_queue_top dut (
    .clk(clk),
    .rst_n(rst_n),
    .start(start),
    .busy(busy),
    .in_data(in_data),
    .out_valid(out_valid),
    .out_data(out_data),
    .psel(psel),
    .penable(penable),
    .pwrite(pwrite),
    .paddr(paddr),
    .pwdata(pwdata),
    .prdata(prdata),
    .pready(pready)
  );

  // 10 ns clock
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic report_mismatch(string what, logic [laq_pkg::WORD_W-1:0] got,
                                 logic [laq_pkg::WORD_W-1:0] want);
    mismatch_count++;
    $display("mismatch on %s: got %h, expected %h", what, got, want);
  endtask

  // linear queue: full once the tail reaches the clamped capacity minus one
  function automatic bit shadow_full();
    int unsigned lim;
    lim = 32'(shadow_cap);
    if (lim < 1) lim = 1;
    if (lim > SLOTS) lim = SLOTS;
    return !shadow_empty && shadow_tail >= lim - 1;
  endfunction

  // apply one request to the shadow queue and give the answer it should produce
  function automatic laq_pkg::laq_out_t queue_answer(laq_pkg::laq_in_t req);
    laq_pkg::laq_out_t ans;
    ans = '0;
    ans.status = laq_pkg::ST_DONE;
    if (req.req_type == laq_pkg::REQ_ENQ) begin
      if (shadow_full()) begin
        ans.status = laq_pkg::ST_FULL;
      end else if (shadow_empty) begin
        shadow_head = 0;
        shadow_tail = 0;
        shadow_slots[0] = req.push_value;
        shadow_empty = 1'b0;
        shadow_held = 1;
      end else begin
        shadow_tail++;
        if (shadow_tail >= SLOTS) shadow_tail = SLOTS - 1;
        shadow_slots[shadow_tail] = req.push_value;
        shadow_held++;
      end
    end else if (shadow_empty) begin
      ans.status = laq_pkg::ST_EMPTY;
    end else if (req.req_type == laq_pkg::REQ_DEQ) begin
      ans.read_value = shadow_slots[shadow_head % SLOTS];
      shadow_held--;
      // draining completely rewinds both pointers
      if (shadow_head >= shadow_tail) begin
        shadow_head = 0;
        shadow_tail = 0;
        shadow_empty = 1'b1;
        shadow_held = 0;
      end else begin
        shadow_head++;
      end
    end else if (req.req_type == laq_pkg::REQ_PEEK_FRONT) begin
      ans.read_value = shadow_slots[shadow_head % SLOTS];
    end else begin
      ans.read_value = shadow_slots[shadow_tail % SLOTS];
    end
    ans.full_flag = shadow_full();
    ans.empty_flag = shadow_empty;
    ans.item_count = shadow_held[laq_pkg::OUT_CNT_W-1:0];
    return ans;
  endfunction

  // send one request word and hold it until it is taken
  task automatic send_word(laq_pkg::laq_req_t kind, logic [laq_pkg::WORD_W-1:0] value);
    laq_pkg::laq_in_t req;
    int gap;
    req.req_type = kind;
    req.push_value = value;
    gap = (idle_max == 0) ? 0 : int'($urandom_range(0, idle_max));
    pending_answers.push_back(queue_answer(req));
    in_data <= req;
    start <= 1'b1;
    do @(posedge clk); while (busy);
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk);
    end
  endtask

  // stop sending and let every outstanding result arrive
  task automatic wait_for_answers();
    int guard;
    guard = 0;
    start <= 1'b0;
    while (pending_answers.size() != 0 && guard < 2000) begin
      @(posedge clk);
      guard++;
    end
    repeat (3) @(posedge clk);
  endtask

  // write the capacity register, then read it back
  task automatic set_capacity(logic [laq_pkg::CAP_W-1:0] cap);
    logic [laq_pkg::CFG_DW-1:0] reg_word;
    reg_word = '0;
    reg_word[laq_pkg::CAP_W-1:0] = cap;
    psel <= 1'b1;
    pwrite <= 1'b1;
    penable <= 1'b0;
    paddr <= CAP_ADDR;
    pwdata <= reg_word;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    shadow_cap = cap;
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== reg_word) report_mismatch("capacity readback", prdata, reg_word);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // requests on an empty queue, extreme words and the dequeue sentinel
  task automatic test_empty_and_extremes();
    idle_max = 15;
    send_word(laq_pkg::REQ_DEQ, $urandom());
    send_word(laq_pkg::REQ_PEEK_FRONT, $urandom());
    send_word(laq_pkg::REQ_PEEK_REAR, $urandom());
    send_word(laq_pkg::REQ_ENQ, 32'h8000_0000);
    send_word(laq_pkg::REQ_ENQ, 32'h7fff_ffff);
    send_word(laq_pkg::REQ_ENQ, SENTINEL);
    send_word(laq_pkg::REQ_PEEK_FRONT, $urandom());
    send_word(laq_pkg::REQ_PEEK_REAR, $urandom());
    repeat (4) send_word(laq_pkg::REQ_DEQ, $urandom());
    wait_for_answers();
  endtask

  // zero capacity, and capacity lowered below a tail already in use
  task automatic test_capacity_limits();
    set_capacity('0);
    send_word(laq_pkg::REQ_ENQ, $urandom());
    send_word(laq_pkg::REQ_ENQ, $urandom());
    send_word(laq_pkg::REQ_PEEK_REAR, $urandom());
    send_word(laq_pkg::REQ_DEQ, $urandom());
    wait_for_answers();
    set_capacity(9'd256);
    repeat (4) send_word(laq_pkg::REQ_ENQ, $urandom());
    wait_for_answers();
    set_capacity(9'd2);
    send_word(laq_pkg::REQ_ENQ, $urandom());
    send_word(laq_pkg::REQ_PEEK_REAR, $urandom());
    repeat (4) send_word(laq_pkg::REQ_DEQ, $urandom());
    wait_for_answers();
  endtask

  // fill-then-drain cycles with random content over a range of capacities
  task automatic test_random_traffic();
    logic [laq_pkg::CAP_W-1:0] caps [10] = '{9'd1, 9'd2, 9'd8, 9'd256, 9'd511,
                                             9'd37, 9'd0, 9'd64, 9'd3, 9'd300};
    int lengths [10] = '{80, 80, 150, 420, 380, 200, 60, 200, 80, 200};
    bit draining;
    int pick;
    laq_pkg::laq_req_t kind;
    caps[9] = laq_pkg::CAP_W'($urandom_range(9, 511));
    for (int p = 0; p < 10; p++) begin
      set_capacity(caps[p]);
      draining = 1'b0;
      for (int i = 0; i < lengths[p]; i++) begin
        if (i % 32 == 0) idle_max = ($urandom_range(0, 2) == 0) ? 0 : 15;
        if (shadow_full()) draining = 1'b1;
        else if (shadow_empty) draining = 1'b0;
        pick = int'($urandom_range(0, 99));
        if (pick < 10) kind = laq_pkg::laq_req_t'($urandom_range(0, 3));
        else if (pick < 15) kind = laq_pkg::REQ_PEEK_FRONT;
        else if (pick < 20) kind = laq_pkg::REQ_PEEK_REAR;
        else if (pick < 27) kind = draining ? laq_pkg::REQ_ENQ : laq_pkg::REQ_DEQ;
        else kind = draining ? laq_pkg::REQ_DEQ : laq_pkg::REQ_ENQ;
        send_word(kind, $urandom());
      end
      wait_for_answers();
    end
  endtask

  // compare each result with the oldest expectation
  always @(posedge clk) begin : check_answers
    laq_pkg::laq_out_t want;
    if (rst_n && out_valid) begin
      if (pending_answers.size() == 0) begin
        report_mismatch("result with nothing expected", out_data.read_value, '0);
      end else begin
        want = pending_answers.pop_front();
        if (out_data.read_value !== want.read_value)
          report_mismatch("read_value", out_data.read_value, want.read_value);
        if (out_data.status !== want.status)
          report_mismatch("status", laq_pkg::WORD_W'(out_data.status),
                          laq_pkg::WORD_W'(want.status));
        if (out_data.full_flag !== want.full_flag)
          report_mismatch("full_flag", laq_pkg::WORD_W'(out_data.full_flag),
                          laq_pkg::WORD_W'(want.full_flag));
        if (out_data.empty_flag !== want.empty_flag)
          report_mismatch("empty_flag", laq_pkg::WORD_W'(out_data.empty_flag),
                          laq_pkg::WORD_W'(want.empty_flag));
        if (out_data.item_count !== want.item_count)
          report_mismatch("item_count", laq_pkg::WORD_W'(out_data.item_count),
                          laq_pkg::WORD_W'(want.item_count));
      end
    end
  end

  // test sequence
  initial begin
    repeat (5) @(posedge clk);
    rst_n <= 1'b1;
    test_empty_and_extremes();
    test_capacity_limits();
    test_random_traffic();
    if (pending_answers.size() != 0)
      report_mismatch("results never seen", laq_pkg::WORD_W'(pending_answers.size()), '0);
    if (mismatch_count == 0) begin
      $display("status: pass");
    end else begin
      $display("status: fail");
    end
    $finish;
  end

  // watchdog
  initial begin
    #(2_000_000);
    $display("status: fail");
    $finish;
  end

endmodule

@@ sim.f @@
+incdir+rtl/core
rtl/core/laq_pkg.sv
rtl/core/laq_ram.sv
rtl/core/laq_cfg.sv
rtl/core/laq_ctrl.sv
rtl/core/linear_array_queue_top.sv
test/linear_array_queue_top_test.sv
